// ===== hdl/sads_pkg.sv =====
// ----------------------------------------------------------------------------
// sads_pkg
// Shared widths, controller states, datapath operations and the command and
// status bundles of the distinct substring counter.
// ----------------------------------------------------------------------------
package sads_pkg;

  localparam int BYTE_W      = 8;
  localparam int OUT_W       = 24;
  localparam int NUM_SYMS    = 256;
  localparam int MAX_LEN_DEF = 4096;

  typedef enum logic [4:0] {
    ST_LOAD, ST_CLR, ST_HIST_A, ST_HIST_B, ST_HIST_C, ST_SUM_A, ST_SUM_B,
    ST_SCAT_A, ST_SCAT_B, ST_SCAT_C, ST_SCAT_D, ST_RANK_A, ST_RANK_B,
    ST_RANK_C, ST_COPY_A, ST_COPY_B, ST_CHECK, ST_T_INIT, ST_T_TAIL, ST_T_A,
    ST_T_B, ST_K_A, ST_K_B, ST_K_C, ST_K_D, ST_K_E, ST_K_F, ST_MUL, ST_FIN
  } ctl_state_t;

  typedef enum logic [4:0] {
    OP_LOAD, OP_CLR, OP_HIST_A, OP_HIST_B, OP_HIST_C, OP_SUM_A, OP_SUM_B,
    OP_SCAT_A, OP_SCAT_B, OP_SCAT_C, OP_SCAT_D, OP_RANK_A, OP_RANK_B,
    OP_RANK_C, OP_COPY_A, OP_COPY_B, OP_CHECK, OP_T_INIT, OP_T_TAIL, OP_T_A,
    OP_T_B, OP_K_A, OP_K_B, OP_K_C, OP_K_D, OP_K_E, OP_K_F, OP_MUL, OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic last_fire;
    logic i_last;
    logic lv0;
    logic more_pass;
    logic rk_zero;
    logic bound_ok;
    logic chars_eq;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/sads_in_if.sv =====
// ----------------------------------------------------------------------------
// sads_in_if
// Input channel: one text byte per word with an end-of-string flag.
// ----------------------------------------------------------------------------
interface sads_in_if import sads_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

// ===== hdl/sads_out_if.sv =====
// ----------------------------------------------------------------------------
// sads_out_if
// Result channel: distinct substring count and overflow flag.
// ----------------------------------------------------------------------------
interface sads_out_if import sads_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] distinct_count;
  logic             overflow;

  modport source (output valid, output distinct_count, output overflow, input ready);
  modport sink   (input valid, input distinct_count, input overflow, output ready);
endinterface

// ===== hdl/sads_ctrl.sv =====
// ----------------------------------------------------------------------------
// sads_ctrl
// Sequencer: load, counting-sort doubling passes, lcp sweep, result.
// ----------------------------------------------------------------------------
module sads_ctrl import sads_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:   if (stat.last_fire) state_nxt = ST_CLR;
      ST_CLR:    if (stat.i_last) state_nxt = ST_HIST_A;
      ST_HIST_A: state_nxt = ST_HIST_B;
      ST_HIST_B: state_nxt = ST_HIST_C;
      ST_HIST_C: state_nxt = stat.i_last ? ST_SUM_A : ST_HIST_A;
      ST_SUM_A:  state_nxt = ST_SUM_B;
      ST_SUM_B:  state_nxt = stat.i_last ? ST_SCAT_A : ST_SUM_A;
      ST_SCAT_A: state_nxt = ST_SCAT_B;
      ST_SCAT_B: state_nxt = stat.lv0 ? ST_SCAT_D : ST_SCAT_C;
      ST_SCAT_C: state_nxt = ST_SCAT_D;
      ST_SCAT_D: state_nxt = stat.i_last ? ST_RANK_A : ST_SCAT_A;
      ST_RANK_A: state_nxt = ST_RANK_B;
      ST_RANK_B: state_nxt = ST_RANK_C;
      ST_RANK_C: state_nxt = stat.i_last ? ST_COPY_A : ST_RANK_A;
      ST_COPY_A: state_nxt = ST_COPY_B;
      ST_COPY_B: state_nxt = stat.i_last ? ST_CHECK : ST_COPY_A;
      ST_CHECK:  state_nxt = stat.more_pass ? ST_T_INIT : ST_K_A;
      ST_T_INIT: state_nxt = ST_T_TAIL;
      ST_T_TAIL: if (stat.i_last) state_nxt = ST_T_A;
      ST_T_A:    state_nxt = ST_T_B;
      ST_T_B:    state_nxt = stat.i_last ? ST_CLR : ST_T_A;
      ST_K_A:    state_nxt = ST_K_B;
      ST_K_B: begin
        if (!stat.rk_zero) state_nxt = ST_K_C;
        else state_nxt = stat.i_last ? ST_MUL : ST_K_A;
      end
      ST_K_C:    state_nxt = ST_K_D;
      ST_K_D:    state_nxt = stat.bound_ok ? ST_K_E : ST_K_F;
      ST_K_E:    state_nxt = stat.chars_eq ? ST_K_D : ST_K_F;
      ST_K_F:    state_nxt = stat.i_last ? ST_MUL : ST_K_A;
      ST_MUL:    state_nxt = ST_FIN;
      ST_FIN:    if (stat.out_free) state_nxt = ST_LOAD;
      default:   state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    unique case (state_r)
      ST_LOAD:   cmd.op = OP_LOAD;
      ST_CLR:    cmd.op = OP_CLR;
      ST_HIST_A: cmd.op = OP_HIST_A;
      ST_HIST_B: cmd.op = OP_HIST_B;
      ST_HIST_C: cmd.op = OP_HIST_C;
      ST_SUM_A:  cmd.op = OP_SUM_A;
      ST_SUM_B:  cmd.op = OP_SUM_B;
      ST_SCAT_A: cmd.op = OP_SCAT_A;
      ST_SCAT_B: cmd.op = OP_SCAT_B;
      ST_SCAT_C: cmd.op = OP_SCAT_C;
      ST_SCAT_D: cmd.op = OP_SCAT_D;
      ST_RANK_A: cmd.op = OP_RANK_A;
      ST_RANK_B: cmd.op = OP_RANK_B;
      ST_RANK_C: cmd.op = OP_RANK_C;
      ST_COPY_A: cmd.op = OP_COPY_A;
      ST_COPY_B: cmd.op = OP_COPY_B;
      ST_CHECK:  cmd.op = OP_CHECK;
      ST_T_INIT: cmd.op = OP_T_INIT;
      ST_T_TAIL: cmd.op = OP_T_TAIL;
      ST_T_A:    cmd.op = OP_T_A;
      ST_T_B:    cmd.op = OP_T_B;
      ST_K_A:    cmd.op = OP_K_A;
      ST_K_B:    cmd.op = OP_K_B;
      ST_K_C:    cmd.op = OP_K_C;
      ST_K_D:    cmd.op = OP_K_D;
      ST_K_E:    cmd.op = OP_K_E;
      ST_K_F:    cmd.op = OP_K_F;
      ST_MUL:    cmd.op = OP_MUL;
      ST_FIN:    cmd.op = OP_FIN;
      default:   cmd.op = OP_LOAD;
    endcase
  end

endmodule

// ===== hdl/sads_dp.sv =====
// ----------------------------------------------------------------------------
// sads_dp
// Datapath: text, suffix order and rank memories, bucket counters, lcp and
// count arithmetic, result register.
// ----------------------------------------------------------------------------
module sads_dp import sads_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  sads_in_if.sink      in_ch,
  sads_out_if.source   out_ch,
  input  dp_cmd_t      cmd,
  output dp_stat_t     stat
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = AW + 1;
  localparam int BK = (MAX_LEN > NUM_SYMS) ? MAX_LEN : NUM_SYMS;
  localparam int BW = $clog2(BK);
  localparam int IW = (BW > CW) ? BW : CW;
  localparam int SW = IW + 1;
  localparam int KW = (AW > BYTE_W) ? AW : BYTE_W;
  localparam int PW = 2 * CW;

  // storage
  logic [BYTE_W-1:0] txt_mem [MAX_LEN];
  logic [AW-1:0]     sa_mem  [MAX_LEN];
  logic [AW-1:0]     tmp_mem [MAX_LEN];
  logic [AW-1:0]     rk_mem  [MAX_LEN];
  logic [AW-1:0]     nrk_mem [MAX_LEN];
  logic [CW-1:0]     cnt_mem [BK];

  logic [BYTE_W-1:0] txt_q0_r, txt_q1_r;
  logic [AW-1:0]     sa_q_r, tmp_q_r, rk_q0_r, rk_q1_r, nrk_q_r;
  logic [CW-1:0]     cnt_q_r;

  // control and working registers
  logic [CW-1:0]    n_r;
  logic             ovf_r;
  logic             lv0_r;
  logic [CW:0]      k_r;
  logic [IW-1:0]    i_r;
  logic [CW-1:0]    p_r;
  logic [CW-1:0]    s_r;
  logic [BW-1:0]    key_r;
  logic [AW-1:0]    x_r;
  logic [AW-1:0]    r_r;
  logic [KW-1:0]    p1_r;
  logic [CW-1:0]    p2_r;
  logic             kv_r;
  logic [AW-1:0]    j_r;
  logic [CW-1:0]    h_r;
  logic [OUT_W-1:0] sum_r;
  logic [PW-1:0]    prod_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] cnt_out_r;
  logic             ovf_out_r;

  // memory port controls
  logic              txt_we, sa_we, tmp_we, rk_we, nrk_we, cnt_we;
  logic [AW-1:0]     txt_wa, txt_ra0, txt_ra1;
  logic [BYTE_W-1:0] txt_wd;
  logic [AW-1:0]     sa_wa, sa_wd, sa_ra;
  logic [AW-1:0]     tmp_wa, tmp_wd, tmp_ra;
  logic [AW-1:0]     rk_wa, rk_wd, rk_ra0, rk_ra1;
  logic [AW-1:0]     nrk_wa, nrk_wd, nrk_ra;
  logic [BW-1:0]     cnt_wa, cnt_ra;
  logic [CW-1:0]     cnt_wd;

  logic          fire_in;
  logic [IW-1:0] lim, i_adv;
  logic          i_last;
  logic [SW-1:0] ak, ih, jh;
  logic [BW-1:0] hkey;
  logic          sa_ge_k;
  logic [KW-1:0] key1;
  logic [CW-1:0] key2;
  logic          differ;
  logic [AW-1:0] rank_nxt;
  logic [CW-1:0] np1;

  assign fire_in     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (cmd.op == OP_LOAD);

  assign lim = (lv0_r && (cmd.op == OP_CLR || cmd.op == OP_SUM_B)) ?
               IW'(NUM_SYMS - 1) : IW'(n_r) - IW'(1);
  assign i_last = (i_r == lim);
  assign i_adv  = i_last ? '0 : i_r + IW'(1);

  assign ak      = SW'(sa_q_r) + SW'(k_r);
  assign ih      = SW'(i_r) + SW'(h_r);
  assign jh      = SW'(j_r) + SW'(h_r);
  assign hkey    = lv0_r ? BW'(txt_q0_r) : BW'(rk_q0_r);
  assign sa_ge_k = ((CW + 1)'(sa_q_r) >= k_r);
  assign np1     = n_r + CW'(1);

  // rank keys: first half rank (or byte), second half rank+1 or zero past the end
  assign key1     = lv0_r ? KW'(txt_q0_r) : KW'(rk_q0_r);
  assign key2     = (!lv0_r && kv_r) ? CW'(rk_q1_r) + CW'(1) : '0;
  assign differ   = (i_r != '0) && ((key1 != p1_r) || (key2 != p2_r));
  assign rank_nxt = r_r + AW'(differ);

  always_comb begin
    txt_we  = 1'b0;
    txt_wa  = n_r[AW-1:0];
    txt_wd  = in_ch.text_byte;
    txt_ra0 = i_r[AW-1:0];
    txt_ra1 = jh[AW-1:0];
    sa_we   = 1'b0;
    sa_wa   = cnt_q_r[AW-1:0];
    sa_wd   = x_r;
    sa_ra   = i_r[AW-1:0];
    tmp_we  = 1'b0;
    tmp_wa  = p_r[AW-1:0];
    tmp_wd  = i_r[AW-1:0];
    tmp_ra  = i_r[AW-1:0];
    rk_we   = 1'b0;
    rk_wa   = i_r[AW-1:0];
    rk_wd   = nrk_q_r;
    rk_ra0  = i_r[AW-1:0];
    rk_ra1  = ak[AW-1:0];
    nrk_we  = 1'b0;
    nrk_wa  = x_r;
    nrk_wd  = rank_nxt;
    nrk_ra  = i_r[AW-1:0];
    cnt_we  = 1'b0;
    cnt_wa  = key_r;
    cnt_wd  = cnt_q_r + CW'(1);
    cnt_ra  = i_r[BW-1:0];
    case (cmd.op)
      OP_LOAD:   txt_we = fire_in && (n_r < CW'(MAX_LEN));
      OP_CLR: begin
        cnt_we = 1'b1;
        cnt_wa = i_r[BW-1:0];
        cnt_wd = '0;
      end
      OP_HIST_B: cnt_ra = hkey;
      OP_HIST_C: cnt_we = 1'b1;
      OP_SUM_B: begin
        cnt_we = 1'b1;
        cnt_wa = i_r[BW-1:0];
        cnt_wd = s_r;
      end
      OP_SCAT_B: begin
        cnt_ra = BW'(txt_q0_r);
        rk_ra0 = tmp_q_r;
      end
      OP_SCAT_C: cnt_ra = BW'(rk_q0_r);
      OP_SCAT_D: begin
        sa_we  = 1'b1;
        cnt_we = 1'b1;
      end
      OP_RANK_B: begin
        txt_ra0 = sa_q_r;
        rk_ra0  = sa_q_r;
      end
      OP_RANK_C: nrk_we = 1'b1;
      OP_COPY_B: rk_we = 1'b1;
      OP_T_TAIL: tmp_we = 1'b1;
      OP_T_B: begin
        tmp_we = sa_ge_k;
        tmp_wd = sa_q_r - k_r[AW-1:0];
      end
      OP_K_B:    sa_ra = rk_q0_r - AW'(1);
      OP_K_D:    txt_ra0 = ih[AW-1:0];
      default: ;
    endcase
  end

  // memories, registered read data
  always_ff @(posedge clk) begin
    if (txt_we) txt_mem[txt_wa] <= txt_wd;
    txt_q0_r <= txt_mem[txt_ra0];
    txt_q1_r <= txt_mem[txt_ra1];
  end

  always_ff @(posedge clk) begin
    if (sa_we) sa_mem[sa_wa] <= sa_wd;
    sa_q_r <= sa_mem[sa_ra];
  end

  always_ff @(posedge clk) begin
    if (tmp_we) tmp_mem[tmp_wa] <= tmp_wd;
    tmp_q_r <= tmp_mem[tmp_ra];
  end

  always_ff @(posedge clk) begin
    if (rk_we) rk_mem[rk_wa] <= rk_wd;
    rk_q0_r <= rk_mem[rk_ra0];
    rk_q1_r <= rk_mem[rk_ra1];
  end

  always_ff @(posedge clk) begin
    if (nrk_we) nrk_mem[nrk_wa] <= nrk_wd;
    nrk_q_r <= nrk_mem[nrk_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_q_r <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      lv0_r       <= 1'b1;
      k_r         <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          if (fire_in) begin
            if (n_r < CW'(MAX_LEN)) n_r <= n_r + CW'(1);
            else ovf_r <= 1'b1;
            if (in_ch.last_byte) begin
              lv0_r <= 1'b1;
              k_r   <= (CW + 1)'(1);
              i_r   <= '0;
            end
          end
        end
        OP_CLR:    i_r <= i_adv;
        OP_HIST_B: key_r <= hkey;
        OP_HIST_C: begin
          i_r <= i_adv;
          if (i_last) s_r <= '0;
        end
        OP_SUM_B: begin
          s_r <= s_r + cnt_q_r;
          i_r <= i_adv;
        end
        OP_SCAT_B: begin
          if (lv0_r) begin
            key_r <= BW'(txt_q0_r);
            x_r   <= i_r[AW-1:0];
          end else begin
            x_r <= tmp_q_r;
          end
        end
        OP_SCAT_C: key_r <= BW'(rk_q0_r);
        OP_SCAT_D: begin
          i_r <= i_adv;
          if (i_last) r_r <= '0;
        end
        OP_RANK_B: begin
          x_r  <= sa_q_r;
          kv_r <= (ak < SW'(n_r));
        end
        OP_RANK_C: begin
          r_r  <= rank_nxt;
          p1_r <= key1;
          p2_r <= key2;
          i_r  <= i_adv;
        end
        OP_COPY_B: begin
          i_r <= i_adv;
          if (i_last && !lv0_r) k_r <= k_r << 1;
        end
        OP_CHECK: begin
          h_r   <= '0;
          sum_r <= '0;
          i_r   <= '0;
        end
        OP_T_INIT: begin
          lv0_r <= 1'b0;
          p_r   <= '0;
          i_r   <= IW'(n_r) - IW'(k_r);
        end
        OP_T_TAIL: begin
          p_r <= p_r + CW'(1);
          i_r <= i_adv;
        end
        OP_T_B: begin
          if (sa_ge_k) p_r <= p_r + CW'(1);
          i_r <= i_adv;
        end
        OP_K_B: begin
          if (rk_q0_r == '0) begin
            h_r <= '0;
            i_r <= i_adv;
          end
        end
        OP_K_C:    j_r <= sa_q_r;
        OP_K_E:    if (txt_q0_r == txt_q1_r) h_r <= h_r + CW'(1);
        OP_K_F: begin
          sum_r <= sum_r + OUT_W'(h_r);
          h_r   <= (h_r != '0) ? h_r - CW'(1) : h_r;
          i_r   <= i_adv;
        end
        OP_MUL:    prod_r <= PW'(n_r) * PW'(np1);
        OP_FIN: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            cnt_out_r   <= OUT_W'(prod_r >> 1) - sum_r;
            ovf_out_r   <= ovf_r;
            n_r         <= '0;
            ovf_r       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.distinct_count = cnt_out_r;
  assign out_ch.overflow       = ovf_out_r;

  assign stat.last_fire = fire_in && in_ch.last_byte;
  assign stat.i_last    = i_last;
  assign stat.lv0       = lv0_r;
  assign stat.more_pass = (k_r < (CW + 1)'(n_r)) && ((CW'(r_r) + CW'(1)) < n_r);
  assign stat.rk_zero   = (rk_q0_r == '0);
  assign stat.bound_ok  = (ih < SW'(n_r)) && (jh < SW'(n_r));
  assign stat.chars_eq  = (txt_q0_r == txt_q1_r);
  assign stat.out_free  = !out_valid_r;

endmodule

// ===== hdl/suffix_array_distinct_substrings_unit.sv =====
// ----------------------------------------------------------------------------
// suffix_array_distinct_substrings_unit
// Counts the distinct nonempty substrings of a byte string.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while loading; bytes past MAX_LEN are dropped
// and flagged as overflow. After the last byte the block sorts the suffixes
// by prefix doubling (one byte-level counting sort, then up to ceil(log2(n))
// rank passes) and sums adjacent longest common prefixes with a linear lcp
// sweep, then returns n(n+1)/2 minus that sum. The counting sorts are paced
// by the bucket counter memory (one read and one write port), whose
// read-modify-write and registered reads spread each element of a sweep over
// its own run of states (HIST_A to HIST_C, SCAT_A to SCAT_D). No input is
// taken while a string is processed; a finished result waits in the output
// register while the next string loads.
module suffix_array_distinct_substrings_unit import sads_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  sads_in_if.sink      in_chan,
  sads_out_if.source   out_chan
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sads_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  sads_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_chan),
    .out_ch (out_chan),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

// ===== hdl/sads_checker.sv =====
// ----------------------------------------------------------------------------
// sads_checker
// Port-level checks on the distinct substring counter.
// ----------------------------------------------------------------------------
module sads_checker import sads_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_last,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] out_count,
  input logic             out_ovf
);

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_ovf))
    else $error("result word changed while stalled");

  // input closes once the last byte is taken
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input open right after last byte");

  // a nonempty string always has at least one substring
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count != '0)
    else $error("zero count on result");

  // no result appears while bytes are still being taken
  a_no_result_mid_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result rose during load");

endmodule

bind suffix_array_distinct_substrings_unit sads_checker u_sads_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_last   (in_chan.last_byte),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_count (out_chan.distinct_count),
  .out_ovf   (out_chan.overflow)
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives byte strings into the distinct substring counter and checks each
// count and overflow flag against a direct suffix sort of the same string.
// ----------------------------------------------------------------------------
module tb;
  import sads_pkg::*;

  typedef struct {
    logic [OUT_W-1:0] cnt;
    logic             ovf;
  } substr_result_t;

  class substr_scoreboard;
    logic [BYTE_W-1:0] text[$];
    int                total_len;
    substr_result_t    pending[$];
    int                errors;
    int                strings_seen;

    function automatic bit suffix_less(int a, int b);
      int n;
      n = text.size();
      while (a < n && b < n) begin
        if (text[a] != text[b]) return text[a] < text[b];
        a++;
        b++;
      end
      return a >= n;
    endfunction

    function automatic logic [OUT_W-1:0] count_distinct();
      int order[];
      int n;
      int tmp;
      int j;
      int p;
      longint total;
      n = text.size();
      order = new[n];
      for (int i = 0; i < n; i++) begin
        tmp = i;
        j = i;
        while (j > 0 && suffix_less(tmp, order[j-1])) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = tmp;
      end
      total = longint'(n) * (n + 1) / 2;
      for (int i = 1; i < n; i++) begin
        p = 0;
        while (order[i-1] + p < n && order[i] + p < n &&
               text[order[i-1] + p] == text[order[i] + p]) p++;
        total -= p;
      end
      return total[OUT_W-1:0];
    endfunction

    function void note_word(logic [BYTE_W-1:0] b, logic last);
      substr_result_t r;
      if (text.size() < MAX_LEN_DEF) text.push_back(b);
      total_len++;
      if (last) begin
        r.cnt = count_distinct();
        r.ovf = total_len > MAX_LEN_DEF;
        pending.push_back(r);
        text.delete();
        total_len = 0;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] cnt, logic ovf);
      substr_result_t r;
      strings_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result count=%0d overflow=%0b", $time, cnt, ovf);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (cnt !== r.cnt) begin
        $display("%0t: count expected %0d actual %0d", $time, r.cnt, cnt);
        errors++;
      end
      if (ovf !== r.ovf) begin
        $display("%0t: overflow expected %0b actual %0b", $time, r.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 8000000;

  logic clk;
  logic rst_n;

  sads_in_if  in_chan ();
  sads_out_if out_chan ();

  suffix_array_distinct_substrings_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  substr_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;
  int words_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // handshake signals only change at the rising edge, so sample mid cycle
  always @(negedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_result(out_chan.distinct_count, out_chan.overflow);
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_word(logic [BYTE_W-1:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.text_byte <= b;
    in_chan.last_byte <= last;
    @(negedge clk);
    while (!in_chan.ready) @(negedge clk);
    @(posedge clk);
    sb.note_word(b, last);
    words_sent++;
  endtask

  task automatic send_string(logic [BYTE_W-1:0] s[$]);
    for (int i = 0; i < s.size(); i++) send_word(s[i], i == s.size() - 1);
  endtask

  task automatic send_random_string(int len, int alpha);
    logic [BYTE_W-1:0] s[$];
    for (int i = 0; i < len; i++)
      s.push_back(alpha >= 256 ? BYTE_W'($urandom_range(255))
                               : BYTE_W'(8'h61 + $urandom_range(alpha - 1)));
    send_string(s);
  endtask

  initial begin
    int len;
    int alpha;
    sb = new();
    words_sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.text_byte = '0;
    in_chan.last_byte = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single bytes at the extremes, zero byte, repeats, periodic text
    send_string('{8'h01});
    send_string('{8'hff});
    send_string('{8'h00});
    send_string('{8'h00, 8'hff, 8'h00});
    send_string('{8'h61, 8'h61, 8'h61, 8'h61, 8'h61});
    send_string('{8'h61, 8'h62, 8'h61, 8'h62, 8'h61, 8'h62, 8'h61});
    send_string('{8'h62, 8'h61, 8'h6e, 8'h61, 8'h6e, 8'h61});

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 74 : 0;
      recv_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 27 : 0;
      for (int i = 0; i < 300; ) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
        case ($urandom_range(2))
          0: alpha = 2;
          1: alpha = 4;
          default: alpha = 256;
        endcase
        send_random_string(len, alpha);
        i += len;
      end
    end

    in_chan.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("covered %0d words in %0d strings, incl. zero bytes, repeats and stalls",
             words_sent, sb.strings_seen);
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/sads_pkg.sv
hdl/sads_in_if.sv
hdl/sads_out_if.sv
hdl/sads_ctrl.sv
hdl/sads_dp.sv
hdl/suffix_array_distinct_substrings_unit.sv
hdl/sads_checker.sv
sim/tb.sv
